// ----- rtl/zmwae_pkg.sv -----
// ---------------------------------------------------------------------------
// Zero-marked word array engine package
// Shared opcodes, status codes and the per-cell control bundle.
// ---------------------------------------------------------------------------
package zmwae_pkg;

   localparam int WORD_W  = 32;
   localparam int POS_W   = 8;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
   localparam logic [OP_W-1:0] OP_SORT_UP   = 3'd4;
   localparam logic [OP_W-1:0] OP_SORT_DOWN = 3'd5;
   localparam logic [OP_W-1:0] OP_READ      = 3'd6;

   localparam logic [STAT_W-1:0] STATUS_DONE   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BADPOS = 2'd2;

   // Control broadcast from the sequencer to every cell in the row
   typedef struct packed {
      logic                     wr_en;
      logic                     clr_en;
      logic                     ins_en;
      logic                     match_en;
      logic                     sort_en;
      logic                     descending;
      logic                     parity;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ----- rtl/zmwae_cell.sv -----
// ---------------------------------------------------------------------------
// Array cell
// Holds one slot; writes, clears, shifts on insert, flags a search match and
// exchanges its word with the right neighbor during a transposition phase.
// ---------------------------------------------------------------------------
module zmwae_cell
   import zmwae_pkg::*;
#(
   parameter int   INDEX = 0,
   parameter logic LAST  = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic signed [WORD_W-1:0] left_word,
   input  logic                     left_chain,
   input  logic                     left_swap,
   input  logic signed [WORD_W-1:0] right_word,
   output logic signed [WORD_W-1:0] word,
   output logic                     chain_out,
   output logic                     swap_out,
   output logic                     match
);

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     match_ff, match_in;
   logic                     selected;
   logic                     pair_active;
   logic                     out_of_order;

   assign selected    = (ctrl.position == POS_W'(INDEX));
   assign pair_active = ctrl.sort_en && !LAST && (ctrl.parity == INDEX[0]);

   // Compare with right neighbor in the requested direction
   assign out_of_order = ctrl.descending ? (word_ff < right_word) : (word_ff > right_word);
   assign swap_out     = pair_active && out_of_order;

   // Run of non-zero words from slot 0 through this one
   assign chain_out = left_chain && (word_ff != '0);

   // Pick next slot content
   always_comb begin
      word_in = word_ff;
      if (ctrl.wr_en && selected) begin
         word_in = ctrl.value;
      end else if (ctrl.clr_en && selected) begin
         word_in = '0;
      end else if (ctrl.ins_en && left_chain) begin
         word_in = left_word;
      end else if (swap_out) begin
         word_in = right_word;
      end else if (left_swap) begin
         word_in = left_word;
      end
   end

   assign match_in = ctrl.match_en ? (word_ff == ctrl.value) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   // Hold match flag until the next search
   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

// ----- rtl/zero_marked_word_array_engine.sv -----
// ---------------------------------------------------------------------------
// Zero-marked word array engine
// Row of ENTRIES slot cells with a small sequencer for write, clear, insert,
// search, odd-even transposition sort and read requests.
// ---------------------------------------------------------------------------
// Sequence: an accepted request steps through ST_EXEC and then ST_FINISH, which
// registers rsp_strobe; a sort runs ST_SORT in between (one transposition phase
// per cycle through the cell row). A new request is accepted only in ST_IDLE;
// busy drops in the cycle that carries rsp_strobe, so a new start is taken there.
// Reset: clears all slots to zero, the occupancy count and the sequencer.
// The receiver cannot stall: each response is valid for one cycle only.
module zero_marked_word_array_engine
   import zmwae_pkg::*;
#(
   parameter int ENTRIES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic signed [WORD_W-1:0] rsp_read_word,
   output logic [COUNT_W-1:0]       rsp_occupancy
);

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PHASE_W = IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SORT,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [OP_W-1:0]          op_ff;
   logic signed [WORD_W-1:0] value_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [PHASE_W-1:0]       phase_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic [STAT_W-1:0]        status_ff;
   logic                     rsp_strobe_ff;
   logic [STAT_W-1:0]        rsp_status_ff;
   logic                     rsp_found_ff;
   logic signed [WORD_W-1:0] rsp_read_word_ff;
   logic [COUNT_W-1:0]       rsp_occupancy_ff;

   logic                     accept;
   logic                     pos_ok;
   logic                     count_full;
   cell_ctrl_type            ctrl;

   logic signed [WORD_W-1:0] words [ENTRIES];
   logic [ENTRIES:0]         chain;
   logic [ENTRIES:0]         swap;
   logic [ENTRIES-1:0]       match_bits;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign pos_ok     = (pos_ff < POS_W'(ENTRIES));
   assign count_full = (count_ff >= COUNT_W'(ENTRIES));

   // Broadcast control to the cell row
   always_comb begin
      ctrl            = '0;
      ctrl.position   = pos_ff;
      ctrl.value      = value_ff;
      ctrl.parity     = phase_ff[0];
      ctrl.descending = (op_ff == OP_SORT_DOWN);
      ctrl.sort_en    = (state_ff == ST_SORT);
      if (state_ff == ST_EXEC) begin
         ctrl.wr_en    = (op_ff == OP_WRITE) && pos_ok;
         ctrl.clr_en   = (op_ff == OP_CLEAR) && pos_ok;
         ctrl.ins_en   = (op_ff == OP_INSERT) && !count_full;
         ctrl.match_en = (op_ff == OP_SEARCH);
      end
   end

   // Build the row; slot 0 shifts in the request value on insert
   assign chain[0] = 1'b1;
   assign swap[0]  = 1'b0;

   generate
      for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
         logic signed [WORD_W-1:0] left_w;
         logic signed [WORD_W-1:0] right_w;
         if (i == 0) begin : g_first
            assign left_w = value_ff;
         end else begin : g_inner
            assign left_w = words[i-1];
         end
         if (i == ENTRIES - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_next
            assign right_w = words[i+1];
         end
         zmwae_cell #(
            .INDEX (i),
            .LAST  (i == ENTRIES - 1)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_word  (left_w),
            .left_chain (chain[i]),
            .left_swap  (swap[i]),
            .right_word (right_w),
            .word       (words[i]),
            .chain_out  (chain[i+1]),
            .swap_out   (swap[i+1]),
            .match      (match_bits[i])
         );
      end
   endgenerate

   // Sequence the request, track occupancy and register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         phase_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_opcode;
                  value_ff <= req_value;
                  pos_ff   <= req_position;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               status_ff <= STATUS_DONE;
               phase_ff  <= '0;
               state_ff  <= ST_FINISH;
               case (op_ff) inside
                  OP_WRITE: begin
                     if (!pos_ok) begin
                        status_ff <= STATUS_BADPOS;
                     end else if (!count_full) begin
                        count_ff <= count_ff + COUNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     if (!pos_ok) begin
                        status_ff <= STATUS_BADPOS;
                     end else if (count_ff != '0) begin
                        count_ff <= count_ff - COUNT_W'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (count_full) begin
                        status_ff <= STATUS_FULL;
                     end else begin
                        count_ff <= count_ff + COUNT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (!pos_ok) begin
                        status_ff <= STATUS_BADPOS;
                     end
                  end
                  OP_SORT_UP, OP_SORT_DOWN: begin
                     state_ff <= ST_SORT;
                  end
                  default: begin
                  end
               endcase
            end
            ST_SORT: begin
               phase_ff <= phase_ff + PHASE_W'(1);
               if (phase_ff == PHASE_W'(ENTRIES - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_status_ff    <= status_ff;
               rsp_found_ff     <= (op_ff == OP_SEARCH) && (|match_bits);
               rsp_read_word_ff <= ((op_ff == OP_READ) && pos_ok) ?
                                   words[pos_ff[IDX_W-1:0]] : '0;
               rsp_occupancy_ff <= count_ff;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_read_word = rsp_read_word_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // Responses are single-cycle pulses, spaced by at least one full request
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // An accepted request makes the engine busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Occupancy never leaves its saturation range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ENTRIES))
      else $error("occupancy count beyond array size");

   // Only a successful request returns a non-zero read word or a match
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_DONE)) |-> (!rsp_found && (rsp_read_word == '0)))
      else $error("refused request returned data");

   // The engine is idle in every cycle that carries a response strobe
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while still busy");

endmodule
